/* design/sclb_pkg.sv */
`timescale 1ns / 1ps

package sclb_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] req_t;
  typedef logic [1:0] mode_t;

  // Request codes
  localparam req_t REQ_RX         = 3'd0;
  localparam req_t REQ_TX_SLOT    = 3'd1;
  localparam req_t REQ_TX_START   = 3'd2;
  localparam req_t REQ_HOST_WRITE = 3'd3;
  localparam req_t REQ_HOST_READ  = 3'd4;
  localparam req_t REQ_REARM      = 3'd5;

  // Mode codes
  localparam mode_t MODE_RX      = 2'd0;
  localparam mode_t MODE_READY   = 2'd1;
  localparam mode_t MODE_TX      = 2'd2;
  localparam mode_t MODE_TX_DONE = 2'd3;

  // Character codes
  localparam byte_t CH_SPACE = 8'h20;
  localparam byte_t CH_CR    = 8'h0D;
  localparam byte_t CH_LF    = 8'h0A;
  localparam byte_t CH_GT    = 8'h3E;
  localparam byte_t CH_NUL   = 8'h00;

endpackage

/* design/sclb_ram.sv */
`timescale 1ns / 1ps

module sclb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/serial_command_line_buffer.sv */
`timescale 1ns / 1ps

// Flow: an accepted item is held in the input register, then its result is presented from the
//   result register.
// Throughput: one item per cycle unless out_ready stalls; the next line store read address is
//   formed from the position left by the item in flight, with a write bypass on the store banks.
// Reset: synchronous, active high; clears mode, position, flags and the terminator setting.
//   The line store is not cleared and needs no clearing pass.
module serial_command_line_buffer #(
  parameter int LINE_BYTES = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_data,
  // request channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sclb_pkg::req_t        req_type,
  input  logic                  rx_has_char,
  input  sclb_pkg::byte_t       rx_char,
  input  logic                  rx_overrun,
  input  logic                  response_mode,
  input  logic [5:0]            entry_index,
  input  sclb_pkg::byte_t       entry_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  tx_valid,
  output sclb_pkg::byte_t       tx_char,
  output logic                  line_done,
  output sclb_pkg::mode_t       mode,
  output sclb_pkg::byte_t       read_data
);

  // Position runs 0..LINE_BYTES; store index runs 0..LINE_BYTES-1.
  localparam int PW         = $clog2(LINE_BYTES + 1);
  localparam int IW         = $clog2(LINE_BYTES);
  localparam int BW         = IW - 1;
  localparam int BANK_DEPTH = (LINE_BYTES + 1) / 2;
  localparam logic [PW-1:0] POS_END  = PW'(LINE_BYTES);
  localparam logic [PW-1:0] POS_LAST = PW'(LINE_BYTES - 1);

  // ------------------------------------------------------------------
  // Architectural state
  // ------------------------------------------------------------------
  logic [PW-1:0]        pos;
  sclb_pkg::mode_t      mode_reg;
  logic                 last_cr;
  logic                 last_gt;
  logic                 reply_rx;
  logic                 dgt;
  // Entry 0 lives in a register: overrun and end of transmit write it alongside other writes.
  sclb_pkg::byte_t      entry0;

  // Input stage
  logic                 s1_valid;
  sclb_pkg::req_t       s1_req;
  logic                 s1_has_char;
  sclb_pkg::byte_t      s1_rx_char;
  logic                 s1_overrun;
  logic                 s1_resp;
  logic [5:0]           s1_idx;
  sclb_pkg::byte_t      s1_data;

  // Store bypass for a read issued while the same entry is being written
  logic                 byp_hit;
  sclb_pkg::byte_t      byp_data;

  // ------------------------------------------------------------------
  // Handshake
  // ------------------------------------------------------------------
  logic in_accept;
  logic s1_fire;

  assign cfg_ready = 1'b1;
  assign s1_fire   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_fire;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dgt <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      dgt <= cfg_data;
    end
  end

  // ------------------------------------------------------------------
  // Line store: two banks split by index parity, so that a stored byte and
  // the NUL after it land in different banks in one cycle.
  // ------------------------------------------------------------------
  logic            we_e, we_o;
  logic [BW-1:0]   addr_e, addr_o;
  sclb_pkg::byte_t data_e, data_o;
  sclb_pkg::byte_t q_e, q_o;
  logic [BW-1:0]   rd_addr_in;

  sclb_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_bank_even (
    .clk   (clk),
    .we    (we_e),
    .waddr (addr_e),
    .wdata (data_e),
    .re    (in_accept),
    .raddr (rd_addr_in),
    .rdata (q_e)
  );

  sclb_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_bank_odd (
    .clk   (clk),
    .we    (we_o),
    .waddr (addr_o),
    .wdata (data_o),
    .re    (in_accept),
    .raddr (rd_addr_in),
    .rdata (q_o)
  );

  // ------------------------------------------------------------------
  // Current store byte for the item in the input stage
  // ------------------------------------------------------------------
  logic [IW-1:0]   rd_idx;
  sclb_pkg::byte_t cur;
  logic            idx_ok;

  assign idx_ok = 32'(s1_idx) < 32'(LINE_BYTES);
  assign rd_idx = (s1_req == sclb_pkg::REQ_HOST_READ) ? IW'(s1_idx) : pos[IW-1:0];

  always_comb begin
    if (rd_idx == '0) begin
      cur = entry0;
    end else if (byp_hit) begin
      cur = byp_data;
    end else begin
      cur = rd_idx[0] ? q_o : q_e;
    end
  end

  // ------------------------------------------------------------------
  // Item processing
  // ------------------------------------------------------------------
  logic [PW-1:0]   pos_a;
  logic            rx_cr, rx_lf, rx_gt;
  logic            rx_store, gt_end, nl_end;

  logic [PW-1:0]   pos_next;
  sclb_pkg::mode_t mode_next;
  logic            last_cr_next, last_gt_next, reply_rx_next;
  logic            e0_we;
  sclb_pkg::byte_t e0_data;
  logic            wa_en, wb_en;
  logic [IW-1:0]   wa_idx, wb_idx;
  sclb_pkg::byte_t wa_data, wb_data;
  logic            tx_valid_next, line_done_next;
  sclb_pkg::byte_t tx_char_next, read_data_next;

  // Overrun turns the pending command into a single space before the byte is handled.
  assign pos_a    = s1_overrun ? PW'(1) : pos;
  assign rx_cr    = s1_has_char && (s1_rx_char == sclb_pkg::CH_CR);
  assign rx_lf    = s1_has_char && (s1_rx_char == sclb_pkg::CH_LF);
  assign rx_gt    = s1_has_char && (s1_rx_char == sclb_pkg::CH_GT);
  // Drop printable bytes once the store is full; keep room for the NUL.
  assign rx_store = s1_has_char && (s1_rx_char >= sclb_pkg::CH_SPACE) && (pos_a < POS_LAST);
  assign gt_end   = rx_store && dgt && rx_gt && last_gt;
  // CR ends the line; so does LF that does not follow CR.
  assign nl_end   = !rx_store && (rx_cr || (rx_lf && !last_cr));

  always_comb begin
    pos_next       = pos;
    mode_next      = mode_reg;
    last_cr_next   = last_cr;
    last_gt_next   = last_gt;
    reply_rx_next  = reply_rx;
    e0_we          = 1'b0;
    e0_data        = sclb_pkg::CH_NUL;
    wa_en          = 1'b0;
    wa_idx         = '0;
    wa_data        = sclb_pkg::CH_NUL;
    wb_en          = 1'b0;
    wb_idx         = '0;
    wb_data        = sclb_pkg::CH_NUL;
    tx_valid_next  = 1'b0;
    tx_char_next   = sclb_pkg::CH_NUL;
    line_done_next = 1'b0;
    read_data_next = sclb_pkg::CH_NUL;
    unique case (s1_req)
      sclb_pkg::REQ_RX: begin
        if (mode_reg == sclb_pkg::MODE_RX) begin
          if (s1_overrun) begin
            e0_we   = 1'b1;
            e0_data = sclb_pkg::CH_SPACE;
          end
          if (rx_store) begin
            wa_en    = 1'b1;
            wa_idx   = pos_a[IW-1:0];
            wa_data  = s1_rx_char;
            pos_next = pos_a + PW'(1);
            if (gt_end) begin
              wb_en          = 1'b1;
              wb_idx         = pos_a[IW-1:0] + IW'(1);
              wb_data        = sclb_pkg::CH_NUL;
              pos_next       = '0;
              mode_next      = sclb_pkg::MODE_READY;
              line_done_next = 1'b1;
            end
          end else if (nl_end) begin
            if (pos_a < POS_END) begin
              wa_en   = 1'b1;
              wa_idx  = pos_a[IW-1:0];
              wa_data = sclb_pkg::CH_NUL;
            end
            pos_next       = '0;
            mode_next      = sclb_pkg::MODE_READY;
            line_done_next = 1'b1;
          end else begin
            pos_next = pos_a;
          end
          last_cr_next = rx_cr;
          last_gt_next = rx_gt;
        end
      end
      sclb_pkg::REQ_TX_SLOT: begin
        if (mode_reg == sclb_pkg::MODE_TX) begin
          // End of store counts as NUL.
          if ((pos < POS_END) && (cur != sclb_pkg::CH_NUL)) begin
            tx_valid_next = 1'b1;
            tx_char_next  = cur;
            pos_next      = pos + PW'(1);
          end else begin
            e0_we     = 1'b1;
            e0_data   = sclb_pkg::CH_NUL;
            pos_next  = '0;
            mode_next = reply_rx ? sclb_pkg::MODE_RX : sclb_pkg::MODE_TX_DONE;
          end
        end
      end
      sclb_pkg::REQ_TX_START: begin
        mode_next     = sclb_pkg::MODE_TX;
        reply_rx_next = s1_resp;
      end
      sclb_pkg::REQ_HOST_WRITE: begin
        if (idx_ok) begin
          wa_en   = 1'b1;
          wa_idx  = IW'(s1_idx);
          wa_data = s1_data;
        end
      end
      sclb_pkg::REQ_HOST_READ: begin
        if (idx_ok) begin
          read_data_next = cur;
        end
      end
      sclb_pkg::REQ_REARM: begin
        mode_next = sclb_pkg::MODE_RX;
        pos_next  = '0;
      end
      default: begin
      end
    endcase
  end

  // Route the two byte writes to the banks; entry 0 goes to its register.
  logic wa_ram, wb_ram;
  logic wa_even, wb_even;

  assign wa_ram  = wa_en && (wa_idx != '0);
  assign wb_ram  = wb_en && (wb_idx != '0);
  assign wa_even = wa_ram && !wa_idx[0];
  assign wb_even = wb_ram && !wb_idx[0];

  assign we_e   = s1_fire && (wa_even || wb_even);
  assign addr_e = wa_even ? wa_idx[IW-1:1] : wb_idx[IW-1:1];
  assign data_e = wa_even ? wa_data : wb_data;
  assign we_o   = s1_fire && ((wa_ram && wa_idx[0]) || (wb_ram && wb_idx[0]));
  assign addr_o = (wa_ram && wa_idx[0]) ? wa_idx[IW-1:1] : wb_idx[IW-1:1];
  assign data_o = (wa_ram && wa_idx[0]) ? wa_data : wb_data;

  // Read for the incoming item uses the position left by the item in flight.
  logic [PW-1:0] pos_ahead;
  logic [IW-1:0] rd_idx_in;
  logic          byp_hit_next;

  assign pos_ahead  = s1_fire ? pos_next : pos;
  assign rd_idx_in  = (req_type == sclb_pkg::REQ_HOST_READ) ? IW'(entry_index)
                                                            : pos_ahead[IW-1:0];
  assign rd_addr_in = rd_idx_in[IW-1:1];
  assign byp_hit_next = rd_idx_in[0] ? (we_o && (addr_o == rd_addr_in))
                                     : (we_e && (addr_e == rd_addr_in));

  // ------------------------------------------------------------------
  // Registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      mode_reg  <= sclb_pkg::MODE_RX;
      last_cr   <= 1'b0;
      last_gt   <= 1'b0;
      reply_rx  <= 1'b0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      byp_hit   <= 1'b0;
    end else begin
      if (s1_fire) begin
        pos      <= pos_next;
        mode_reg <= mode_next;
        last_cr  <= last_cr_next;
        last_gt  <= last_gt_next;
        reply_rx <= reply_rx_next;
      end
      if (in_accept) begin
        s1_valid <= 1'b1;
        byp_hit  <= byp_hit_next;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req      <= req_type;
      s1_has_char <= rx_has_char;
      s1_rx_char  <= rx_char;
      s1_overrun  <= rx_overrun;
      s1_resp     <= response_mode;
      s1_idx      <= entry_index;
      s1_data     <= entry_data;
      byp_data    <= rd_idx_in[0] ? data_o : data_e;
    end
    if (s1_fire) begin
      if (wa_en && (wa_idx == '0)) begin
        entry0 <= wa_data;
      end else if (e0_we) begin
        entry0 <= e0_data;
      end
      tx_valid  <= tx_valid_next;
      tx_char   <= tx_char_next;
      line_done <= line_done_next;
      mode      <= mode_next;
      read_data <= read_data_next;
    end
  end

`ifndef SYNTHESIS
  a_done_ready : assert property (@(posedge clk) disable iff (rst)
    out_valid && line_done |-> mode == sclb_pkg::MODE_READY)
    else $error("line end without ready mode");

  a_tx_nonzero : assert property (@(posedge clk) disable iff (rst)
    out_valid && tx_valid |-> tx_char != sclb_pkg::CH_NUL)
    else $error("NUL sent as a byte");

  a_pos_bound : assert property (@(posedge clk) disable iff (rst)
    pos <= POS_END)
    else $error("position beyond end of store");

  a_rx_pos : assert property (@(posedge clk) disable iff (rst)
    mode_reg == sclb_pkg::MODE_RX |-> pos < POS_END)
    else $error("receive mode at end of store");

  a_flow : assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with result register empty");
`endif

endmodule
